// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL sequencer.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A checked property that is ignored while reset is high.
`define XLBG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A checked property that also holds during reset.
`define XLBG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/xlbg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XNOR LFSR bit generator package
// Shared widths, register indexes and sequencer codes.
// ---------------------------------------------------------------------------
package xlbg_pkg;

   localparam int XLBG_REG_WIDTH = 32;
   localparam int COUNT_W        = 7;
   localparam int VALUE_W        = 64;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(64);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_MASK   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_VALUE = 1'b1;

   // Request actions.
   localparam logic ACT_DRAW = 1'b0;
   localparam logic ACT_SKIP = 1'b1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

endpackage

// ===== rtl/xlbg_lfsr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XLBG shift register
// Holds the tap mask and the shift register, and performs one XNOR
// feedback shift per cycle when enabled by the sequencer and no csr write is made.
// ---------------------------------------------------------------------------
module xlbg_lfsr
   import xlbg_pkg::*;
#(
   parameter int REG_WIDTH = XLBG_REG_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]   csr_wdata,
   input  logic                   shift_en,
   output logic                   lsb
);

   logic [REG_WIDTH-1:0] tap_ff;
   logic [REG_WIDTH-1:0] tap_in;
   logic [REG_WIDTH-1:0] shift_ff;
   logic [REG_WIDTH-1:0] shift_in;
   logic                 feedback;

   // An all-zero register always feeds back a one so it cannot lock up.
   assign feedback = (~^(shift_ff & tap_ff)) | (shift_ff == '0);
   assign lsb      = shift_ff[0];

   always_comb begin
      tap_in   = tap_ff;
      shift_in = shift_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TAP_MASK:   tap_in   = csr_wdata;
            CSR_SEED_VALUE: shift_in = csr_wdata;
            default:        ;
         endcase
      end else if (shift_en) begin
         shift_in = {feedback, shift_ff[REG_WIDTH-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff   <= REG_WIDTH'(1);
         shift_ff <= REG_WIDTH'(1);
      end else begin
         tap_ff   <= tap_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// ===== rtl/xlbg_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XLBG sequencer
// Takes one request, steps the shift register once per cycle for the
// requested count, collects the bits unless skipping and holds the response.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xlbg_ctrl
   import xlbg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [COUNT_W-1:0] req_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_value,
   input  logic               lsb,
   output logic               shift_en
);

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               skip_ff;
   logic               skip_in;
   logic [VALUE_W-1:0] acc_ff;
   logic [VALUE_W-1:0] acc_in;
   logic [COUNT_W-1:0] sat_count;
   logic               req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign sat_count  = (req_count > MAX_COUNT) ? MAX_COUNT : req_count;
   assign rsp_valid  = (state_ff == ST_DONE);
   assign rsp_value  = acc_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      skip_in  = skip_ff;
      acc_in   = acc_ff;
      shift_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               count_in = sat_count;
               skip_in  = (req_action == ACT_SKIP);
               acc_in   = '0;
               state_in = (sat_count == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            shift_en = 1'b1;
            // The bit is taken before the shift, so the first one ends up on top.
            if (!skip_ff) begin
               acc_in = {acc_ff[VALUE_W-2:0], lsb};
            end
            count_in = count_ff - COUNT_W'(1);
            if (count_ff == COUNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         skip_ff  <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      acc_ff   <= acc_in;
   end

   `XLBG_ASSERT(a_zero_count_done, (req_accept && req_count == '0) |=> (state_ff == ST_DONE && acc_ff == '0), "zero-count request did not complete at once")
   `XLBG_ASSERT(a_run_count_nonzero, (state_ff == ST_RUN) |-> (count_ff != '0), "sequencer running with no shifts left")
   `XLBG_ASSERT(a_skip_clear, (state_ff != ST_IDLE && skip_ff) |-> (acc_ff == '0), "skip request collected bits")
   `XLBG_ASSERT(a_last_shift_done, (state_ff == ST_RUN && count_ff == COUNT_W'(1)) |=> (state_ff == ST_DONE), "last shift did not finish the request")

endmodule

// ===== rtl/xnor_lfsr_bit_generator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XNOR LFSR bit generator
// A 32-bit right-shifting Fibonacci LFSR with programmable taps that draws
// or skips up to 64 bits per request.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  req       in         req_valid/stall     req_action, req_count
//  rsp       out        rsp_valid/stall     rsp_value
//  csr       in         csr_write           csr_index, csr_wdata
//
// A request with count n (saturated at 64) is accepted in the idle state,
// shifted n times in the run state and answered in the done state. The
// LFSR step unit shifts once per cycle unless a csr write comes. One
// request is in flight at a time; req_stall is high until the response
// has been taken. Reset loads taps and register with one.
// ---------------------------------------------------------------------------
module xnor_lfsr_bit_generator
   import xlbg_pkg::*;
#(
   parameter int REG_WIDTH = XLBG_REG_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [COUNT_W-1:0]     req_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_W-1:0]     rsp_value,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]   csr_wdata
);

   logic shift_en;
   logic lsb;

   xlbg_lfsr #(
      .REG_WIDTH (REG_WIDTH)
   ) u_lfsr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .shift_en  (shift_en),
      .lsb       (lsb)
   );

   xlbg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_count  (req_count),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .lsb        (lsb),
      .shift_en   (shift_en)
   );

endmodule
